// ===== src/wefs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weighted selector package
// Shared constants, register codes, states and the control bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package wefs_pkg;

  localparam int MaxEntries = 8;
  localparam int WeightW    = 8;
  localparam int AccW       = 16;
  localparam int SumW       = 11;
  localparam int IdxW       = 3;
  localparam int CntW       = 4;
  localparam int ChoiceW    = 4;
  localparam int CfgDataW   = 64;
  localparam int CfgIdxW    = 2;

  typedef enum logic [CfgIdxW-1:0] {
    RegWeights = 2'd0,
    RegCount   = 2'd1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    StIdle   = 2'd0,
    StUpdate = 2'd1,
    StFix    = 2'd2,
    StDone   = 2'd3
  } state_e;

  typedef struct packed {
    logic start;
    logic step;
    logic fix;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic go;
    logic last;
  } dp_status_t;

endpackage

// ===== src/wefs_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weighted selector controller
// Sequences one request through the accumulator sweep, the winner update and
// the output register.
// ----------------------------------------------------------------------------
module wefs_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  wefs_pkg::dp_status_t status_i,
  output wefs_pkg::dp_cmd_t    cmd_o
);
  import wefs_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          state_d = status_i.go ? StUpdate : StDone;
        end
      end
      StUpdate: begin
        if (status_i.last) begin
          state_d = StFix;
        end
      end
      StFix: begin
        state_d = StDone;
      end
      StDone: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    in_ready_o     = 1'b0;
    cmd_o          = '0;
    out_valid_d    = out_valid_q && !out_ready_i;
    case (state_q)
      StIdle: begin
        in_ready_o  = 1'b1;
        cmd_o.start = in_valid_i;
      end
      StUpdate: begin
        cmd_o.step = 1'b1;
      end
      StFix: begin
        cmd_o.fix = 1'b1;
      end
      StDone: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
        end
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== src/wefs_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weighted selector datapath
// Holds the configuration, the eight accumulators, the running maximum and
// the output register, and performs one accumulator update per cycle.
// ----------------------------------------------------------------------------
module wefs_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [wefs_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [wefs_pkg::CfgDataW-1:0]    cfg_wdata_i,
  input  logic                             trigger_i,
  input  wefs_pkg::dp_cmd_t                cmd_i,
  output wefs_pkg::dp_status_t             status_o,
  output logic [wefs_pkg::ChoiceW-1:0]     choice_o
);
  import wefs_pkg::*;

  logic [CfgDataW-1:0] weights_q;
  logic [CntW-1:0]     count_q;
  logic [AccW-1:0]     acc_q [MaxEntries];
  logic [IdxW-1:0]     idx_q;
  logic [IdxW-1:0]     best_q;
  logic [AccW-1:0]     best_val_q;
  logic [IdxW-1:0]     last_choice_q;
  logic [ChoiceW-1:0]  choice_q;

  logic [CntW-1:0]     active_n;
  logic [SumW-1:0]     sum;
  logic [WeightW-1:0]  cur_w;
  logic [AccW-1:0]     acc_new;
  logic                take_new;
  logic                wr_weights;
  logic                wr_count;
  logic [IdxW-1:0]     last_idx;

  assign active_n = (count_q > CntW'(MaxEntries)) ? CntW'(MaxEntries) : count_q;
  assign last_idx = active_n[IdxW-1:0] - IdxW'(1);

  always_comb begin
    sum = '0;
    for (int i = 0; i < MaxEntries; i++) begin
      if (CntW'(i) < active_n) begin
        sum = sum + SumW'(weights_q[i*WeightW +: WeightW]);
      end
    end
  end

  assign cur_w    = weights_q[idx_q*WeightW +: WeightW];
  assign acc_new  = acc_q[idx_q] + AccW'(cur_w);
  assign take_new = (idx_q == '0) || ($signed(acc_new) > $signed(best_val_q));

  assign wr_weights = cfg_we_i && (cfg_idx_i == RegWeights);
  assign wr_count   = cfg_we_i && (cfg_idx_i == RegCount);

  assign status_o.go   = trigger_i && (active_n > CntW'(2)) && (sum != '0);
  assign status_o.last = (idx_q == last_idx);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weights_q     <= '0;
      count_q       <= '0;
      last_choice_q <= '0;
      idx_q         <= '0;
      for (int i = 0; i < MaxEntries; i++) begin
        acc_q[i] <= '0;
      end
    end else begin
      if (wr_weights) begin
        weights_q <= cfg_wdata_i;
      end
      if (wr_count) begin
        count_q <= cfg_wdata_i[CntW-1:0];
      end
      if (wr_weights || wr_count) begin
        for (int i = 0; i < MaxEntries; i++) begin
          acc_q[i] <= '0;
        end
      end else if (cmd_i.step) begin
        acc_q[idx_q] <= acc_new;
      end else if (cmd_i.fix) begin
        acc_q[best_q] <= best_val_q - AccW'(sum);
      end
      if (cmd_i.start) begin
        idx_q <= '0;
      end else if (cmd_i.step) begin
        idx_q <= idx_q + IdxW'(1);
      end
      if (cmd_i.fix) begin
        last_choice_q <= best_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step && take_new) begin
      best_q     <= idx_q;
      best_val_q <= acc_new;
    end
    if (cmd_i.load_out) begin
      choice_q <= ChoiceW'(last_choice_q) + ChoiceW'(1);
    end
  end

  assign choice_o = choice_q;

endmodule

// ===== src/weighted_error_feedback_selector_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weighted error-feedback selector core
// Smooth weighted round-robin selector over up to eight weighted entries.
//
// Configuration: write index 0 with eight 8-bit weights (entry 0 in the low
// byte) and index 1 with the active entry count; either write clears all
// accumulators. The user writes only while idle; the core does not enforce it.
// Input: one trigger bit per request on a valid/ready channel. Output: one
// choice (winning index plus one, 1 to 8) per request on a valid/ready channel.
// An advancing request (trigger set, more than two active entries, nonzero
// weight sum) sweeps the accumulators one entry per cycle, then updates the
// winner's accumulator and loads the output register; the core takes no new
// request until the result is in the output register. Any other request
// repeats the previous choice.
// The result sits in an output register, so when the receiver stalls the core
// still runs one further request and then waits for the register to drain.
// Reset clears the configuration, the accumulators and the previous choice,
// so the first repeated choice reads 1.
// ----------------------------------------------------------------------------
module weighted_error_feedback_selector_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [wefs_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [wefs_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          trigger_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [wefs_pkg::ChoiceW-1:0]  choice_o
);
  import wefs_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  wefs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  wefs_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .trigger_i   (trigger_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .choice_o    (choice_o)
  );

  a_choice_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (choice_o != '0) && (choice_o <= ChoiceW'(MaxEntries)))
    else $error("Choice outside the entry range.");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("Core ready again right after taking a request.");

  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("Result produced without a request in progress.");

endmodule

// ===== sim/weighted_error_feedback_selector_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weighted selector core testbench
// Sends trigger requests through the input channel and checks every choice
// against a cycle-free model of the smooth weighted round-robin selection.
// Weights and entry counts are reprogrammed between phases while the core is
// idle, and both channels idle in random bursts until the final phases.
// ----------------------------------------------------------------------------
module weighted_error_feedback_selector_core_test;
  import wefs_pkg::*;

  localparam logic [CfgIdxW-1:0] RegSpareLo = 2'd2;
  localparam logic [CfgIdxW-1:0] RegSpareHi = 2'd3;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i   = RegWeights;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  logic                trigger_i   = 1'b0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [ChoiceW-1:0]  choice_o;

  weighted_error_feedback_selector_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .trigger_i   (trigger_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .choice_o    (choice_o)
  );

  // Selector state as the core should hold it.
  logic [CfgDataW-1:0]     weight_bytes = '0;
  logic [CntW-1:0]         active_cnt   = '0;
  logic signed [AccW-1:0]  sel_acc [MaxEntries];
  logic [IdxW-1:0]         last_pick    = '0;

  logic                    pending_triggers [$];
  logic [ChoiceW-1:0]      expected_choices [$];
  bit                      idle_on = 1'b1;
  int                      send_gap;
  int                      recv_stall;
  int                      mismatch_count;
  int                      choices_checked;
  int                      advances_seen;
  int                      reg_writes;

  initial begin
    for (int i = 0; i < MaxEntries; i++) sel_acc[i] = '0;
  end

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  function automatic logic [ChoiceW-1:0] advance_selector(logic trig);
    logic [CntW-1:0]        n;
    logic [SumW-1:0]        wsum;
    logic [WeightW-1:0]     w;
    logic [IdxW-1:0]        best;
    logic signed [AccW-1:0] best_val;
    n = (active_cnt > MaxEntries) ? CntW'(MaxEntries) : active_cnt;
    if (trig && n > 2) begin
      wsum = '0;
      for (int i = 0; i < n; i++) wsum += SumW'(weight_bytes[WeightW*i +: WeightW]);
      if (wsum != 0) begin
        best     = '0;
        best_val = '0;
        for (int i = 0; i < n; i++) begin
          w = weight_bytes[WeightW*i +: WeightW];
          sel_acc[i] = sel_acc[i] + AccW'(w);
          if (i == 0 || sel_acc[i] > best_val) begin
            best_val = sel_acc[i];
            best     = IdxW'(i);
          end
        end
        sel_acc[best] = sel_acc[best] - AccW'(wsum);
        last_pick = best;
        advances_seen++;
      end
    end
    return ChoiceW'(last_pick) + ChoiceW'(1);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    if (mismatch_count < 20) begin
      $display("ERROR at %0t ns: %s, got %0d, expected %0d", $time, what, got, want);
    end
    mismatch_count++;
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_triggers.size() != 0 || in_valid_i || expected_choices.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      RegWeights: weight_bytes = data;
      RegCount:   active_cnt = data[CntW-1:0];
      default: ;
    endcase
    if (idx == RegWeights || idx == RegCount) begin
      for (int i = 0; i < MaxEntries; i++) sel_acc[i] = '0;
    end
    reg_writes++;
  endtask

  task automatic queue_triggers(int count, logic trig);
    repeat (count) pending_triggers.push_back(trig);
  endtask

  // Request driver.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      trigger_i  <= 1'b0;
      send_gap   = 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        expected_choices.push_back(advance_selector(trigger_i));
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_triggers.size() > 0) begin
          in_valid_i <= 1'b1;
          trigger_i  <= pending_triggers.pop_front();
          if (idle_on && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 17);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      recv_stall  = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_choices.size() == 0) begin
          report_mismatch("choice with no request pending", int'(choice_o), 0);
        end else begin
          if (choice_o !== expected_choices[0]) begin
            report_mismatch("choice", int'(choice_o), int'(expected_choices[0]));
          end
          void'(expected_choices.pop_front());
          choices_checked++;
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_ready_i <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        recv_stall  = $urandom_range(0, 16);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    logic [CfgDataW-1:0] w;
    logic [CntW-1:0]     cnt;
    int                  mode;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset state: nothing active, every choice reads 1.
    queue_triggers(1, 1'b1);
    queue_triggers(1, 1'b0);

    // Equal full weights rotate through the entries in index order.
    write_reg(RegWeights, '1);
    write_reg(RegCount, CfgDataW'(8));
    queue_triggers(4, 1'b1);
    queue_triggers(1, 1'b0);

    // Writes to unlisted indexes must leave the accumulators alone.
    write_reg(RegSpareLo, '1);
    write_reg(RegSpareHi, '1);
    queue_triggers(2, 1'b1);

    // Counts above the entry limit saturate.
    write_reg(RegWeights, 64'h0102_0304_0506_0708);
    write_reg(RegCount, CfgDataW'(15));
    queue_triggers(4, 1'b1);

    // Fewer than three entries holds the previous choice.
    write_reg(RegCount, CfgDataW'(2));
    queue_triggers(2, 1'b1);

    // A zero sum over the active entries holds the previous choice.
    write_reg(RegCount, CfgDataW'(3));
    write_reg(RegWeights, 64'hFFFF_FFFF_FF00_0000);
    queue_triggers(2, 1'b1);

    write_reg(RegWeights, '0);
    write_reg(RegCount, '0);
    queue_triggers(1, 1'b1);

    // Lopsided weights drive the winning accumulator negative.
    write_reg(RegWeights, 64'h0000_0000_00FF_0001);
    write_reg(RegCount, CfgDataW'(3));
    queue_triggers(4, 1'b1);

    for (int phase = 0; phase < 10; phase++) begin
      if (phase >= 8) begin
        wait_idle();
        idle_on = 1'b0;
      end
      mode = $urandom_range(0, 5);
      w = {$urandom, $urandom};
      case (mode)
        0: w = '1;
        1: for (int b = 0; b < MaxEntries; b++) begin
          w[WeightW*b +: WeightW] = WeightW'($urandom_range(0, 3));
        end
        2: for (int b = 0; b < MaxEntries; b++) begin
          if ($urandom_range(0, 2) == 0) w[WeightW*b +: WeightW] = '0;
        end
        default: ;
      endcase
      cnt = ($urandom_range(0, 7) == 0) ? CntW'($urandom_range(0, 15))
                                        : CntW'($urandom_range(3, 8));
      if ($urandom_range(0, 3) == 0) write_reg(RegSpareLo + CfgIdxW'($urandom_range(0, 1)),
                                               {$urandom, $urandom});
      write_reg(RegWeights, w);
      write_reg(RegCount, {$urandom, 16'($urandom), 12'h000, cnt});
      for (int k = 0; k < 80; k++) begin
        pending_triggers.push_back($urandom_range(0, 99) < 85);
      end
    end

    wait_idle();
    repeat (16) @(posedge clk_i);
    $display("Checked %0d choices, %0d of them advancing, across %0d register writes.",
             choices_checked, advances_seen, reg_writes);
    $display("Both channels idled in random bursts before the last two phases.");
    if (mismatch_count == 0) begin
      $display("weighted_error_feedback_selector_core_test passed");
    end else begin
      $display("weighted_error_feedback_selector_core_test failed");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("Timed out with %0d choices outstanding.", expected_choices.size());
    $display("weighted_error_feedback_selector_core_test failed");
    $finish;
  end

endmodule

// ===== files.f =====
src/wefs_pkg.sv
src/wefs_ctrl.sv
src/wefs_dp.sv
src/weighted_error_feedback_selector_core.sv
sim/weighted_error_feedback_selector_core_test.sv
